@@ rtl/smapd_pkg.sv @@
// package for the slider moving-average pd joint controller
// types, constants and slider mapping; no dependencies
package smapd_pkg;
  localparam int unsigned WindowDepth = 64;
  localparam int unsigned JointCount  = 12;
  localparam int unsigned SampleW     = 19;
  localparam int unsigned SumW        = 25;
  localparam int unsigned TorqueW     = 20;
  localparam int unsigned QueueDepth  = 2;
  localparam logic [17:0] PiQ16       = 18'd205887;
  localparam logic [1:0] RegGainP = 2'd0;
  localparam logic [1:0] RegGainD = 2'd1;
  localparam logic [1:0] RegWinLen = 2'd2;
  localparam logic CmdCapture = 1'b0;
  localparam logic CmdTick    = 1'b1;
  localparam logic signed [TorqueW-1:0] TorqueMax = 20'sd524287;
  localparam logic signed [TorqueW-1:0] TorqueMin = -20'sd524288;

  // classified item handed from front to back
  typedef struct packed {
    logic               capture;
    logic               valid_joint;
    logic [3:0]         joint;
    logic signed [18:0] sample;
    logic signed [15:0] position;
    logic signed [15:0] velocity;
    logic               enabled;
  } item_t;

  // map the two sliders onto one joint, Q2.16
  function automatic logic signed [18:0] map_value(input logic [3:0] j,
      input logic [15:0] a, input logic [15:0] b);
    logic [1:0] leg;
    logic [1:0] axis;
    logic signed [18:0] v;
    leg  = (j >= 4'd9) ? 2'd3 : (j >= 4'd6) ? 2'd2 : (j >= 4'd3) ? 2'd1 : 2'd0;
    axis = 2'(j - 4'(leg) * 4'd3);
    case (axis)
      2'd0:    v = $signed({3'b000, a}) - 19'sd32768;
      2'd1:    v = $signed({3'b000, b});
      default: v = 19'sd131072 - $signed({2'b00, b, 1'b0});
    endcase
    if (leg[1] && axis != 2'd0) v = -v;
    if (j == 4'd3 || j == 4'd9) v = -v;
    return v;
  endfunction
endpackage

@@ rtl/smapd_if.sv @@
// valid/ready channel interfaces for the controller
// no dependencies
interface smapd_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [3:0]  joint;
  logic [15:0] knob_a;
  logic [15:0] knob_b;
  logic signed [15:0] joint_position;
  logic signed [15:0] joint_velocity;
  logic        motor_on;
  modport source (output valid, command, joint, knob_a, knob_b, joint_position,
                  joint_velocity, motor_on, input ready);
  modport sink (input valid, command, joint, knob_a, knob_b, joint_position,
                joint_velocity, motor_on, output ready);
endinterface

interface smapd_out_if;
  logic valid;
  logic ready;
  logic signed [19:0] torque;
  logic signed [19:0] desired_position;
  logic saturated;
  modport source (output valid, torque, desired_position, saturated, input ready);
  modport sink (input valid, torque, desired_position, saturated, output ready);
endinterface

interface smapd_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/slider_moving_average_pd_joint.sv @@
// top level of the slider moving-average pd joint controller
// depends on smapd_pkg, smapd_if, smapd_front, smapd_back
//
//   channel  dir  payload
//   in_i     in   command, joint, sliders, position, velocity, enable
//   out_o    out  torque, desired_position, saturated
//   cfg_i    in   index, data
//
// a control tick holds the back end from pop to next pop through the read, sum,
// divide, multiply and pd states, one bit a cycle in the window divider; the
// next pop waits until the result has been taken
// capture and out-of-range joints: result registered in the read state
// reset clears all per-joint state at once; the window ram needs no clearing
// the two-entry input queue accepts while the back end or output stalls, until full
module slider_moving_average_pd_joint #(
  parameter int unsigned WindowDepth = smapd_pkg::WindowDepth
) (
  input  logic clk_i,
  input  logic rst_ni,
  smapd_in_if.sink    in_i,
  smapd_out_if.source out_o,
  smapd_cfg_if.sink   cfg_i
);
  logic [15:0] gain_p_q, gain_d_q;
  logic [6:0]  win_len_q;
  logic        win_clear;
  logic        item_valid, item_pop;
  smapd_pkg::item_t item;

  // configuration registers
  assign cfg_i.ready = 1'b1;
  assign win_clear = cfg_i.valid && cfg_i.index == smapd_pkg::RegWinLen;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_p_q <= 16'd4608; gain_d_q <= 16'd92; win_len_q <= 7'd50;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        smapd_pkg::RegGainP:  gain_p_q <= cfg_i.data;
        smapd_pkg::RegGainD:  gain_d_q <= cfg_i.data;
        smapd_pkg::RegWinLen: win_len_q <= cfg_i.data[6:0];
        default: ;
      endcase
    end
  end

  smapd_front u_front (
    .clk_i, .rst_ni, .in_i, .item_valid_o(item_valid), .item_pop_i(item_pop),
    .item_o(item)
  );
  smapd_back #(.WindowDepth(WindowDepth)) u_back (
    .clk_i, .rst_ni, .item_valid_i(item_valid), .item_pop_o(item_pop),
    .item_i(item), .gain_p_i(gain_p_q), .gain_d_i(gain_d_q),
    .win_len_i(win_len_q), .win_clear_i(win_clear), .out_o
  );
endmodule

@@ rtl/smapd_ram.sv @@
// generic single-port ram with registered read
// no dependencies
module smapd_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[addr_i] <= wdata_i;
    rdata_o <= mem_q[addr_i];
  end
endmodule

@@ rtl/smapd_front.sv @@
// front end: accepts input transactions, maps sliders, queues items
// depends on smapd_pkg and smapd_if
module smapd_front (
  input  logic clk_i,
  input  logic rst_ni,
  smapd_in_if.sink    in_i,
  output logic           item_valid_o,
  input  logic           item_pop_i,
  output smapd_pkg::item_t item_o
);
  localparam int unsigned QD = smapd_pkg::QueueDepth;
  smapd_pkg::item_t q_q [QD];
  logic [$clog2(QD)-1:0] wr_q, rd_q;
  logic [$clog2(QD):0]   cnt_q;
  logic push;
  smapd_pkg::item_t it;

  assign in_i.ready = (cnt_q != ($clog2(QD)+1)'(QD));
  assign push = in_i.valid && in_i.ready;

  // classify incoming transaction
  always_comb begin
    it.capture     = (in_i.command == smapd_pkg::CmdCapture);
    it.valid_joint = 32'(in_i.joint) < smapd_pkg::JointCount;
    it.joint       = in_i.joint;
    it.sample      = smapd_pkg::map_value(in_i.joint, in_i.knob_a, in_i.knob_b);
    it.position    = in_i.joint_position;
    it.velocity    = in_i.joint_velocity;
    it.enabled     = in_i.motor_on;
  end

  // small fifo
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= ($clog2(QD))'((32'(wr_q) + 1) % QD);
      if (item_pop_i) rd_q <= ($clog2(QD))'((32'(rd_q) + 1) % QD);
      cnt_q <= cnt_q + ($clog2(QD)+1)'(push) - ($clog2(QD)+1)'(item_pop_i);
    end
  end
  always_ff @(posedge clk_i) begin
    if (push) q_q[wr_q] <= it;
  end

  assign item_valid_o = cnt_q != '0;
  assign item_o = q_q[rd_q];
endmodule

@@ rtl/smapd_divider.sv @@
// restoring divider: magnitude of a sum by the fill count, one bit a cycle
// no dependencies
module smapd_divider #(
  parameter int unsigned NumW = 24,
  parameter int unsigned DenW = 9
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  output logic            done_o,
  output logic [NumW-1:0] quo_o
);
  logic [NumW-1:0] quo_q;
  logic [DenW-1:0] rem_q;
  logic [DenW-1:0] den_q;
  logic [$clog2(NumW+1)-1:0] cnt_q;
  logic busy_q;
  logic [DenW:0] trial;

  assign trial = {rem_q, quo_q[NumW-1]};

  // shift and subtract per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_o <= 1'b0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= ($clog2(NumW+1))'(NumW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == 1) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_q <= DenW'(trial - {1'b0, den_q});
        quo_q <= {quo_q[NumW-2:0], 1'b1};
      end else begin
        rem_q <= trial[DenW-1:0];
        quo_q <= {quo_q[NumW-2:0], 1'b0};
      end
    end
  end
  assign quo_o = quo_q;
endmodule

@@ rtl/smapd_back.sv @@
// back end: window update, average, pd law, result register
// depends on smapd_pkg, smapd_if, smapd_ram, smapd_divider
module smapd_back #(
  parameter int unsigned WindowDepth = smapd_pkg::WindowDepth
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic             item_valid_i,
  output logic             item_pop_o,
  input  smapd_pkg::item_t item_i,
  input  logic [15:0]      gain_p_i,
  input  logic [15:0]      gain_d_i,
  input  logic [6:0]       win_len_i,
  input  logic             win_clear_i,
  smapd_out_if.source      out_o
);
  localparam int unsigned PW = (WindowDepth > 1) ? $clog2(WindowDepth) : 1;
  localparam int unsigned LW = $clog2(WindowDepth + 1);
  localparam int unsigned AW = $clog2(smapd_pkg::JointCount * WindowDepth);
  localparam int unsigned JC = smapd_pkg::JointCount;

  typedef enum logic [7:0] {
    StIdle = 8'b00000001, StRead = 8'b00000010, StSum  = 8'b00000100,
    StDiv  = 8'b00001000, StMul  = 8'b00010000, StPd1  = 8'b00100000,
    StPd2  = 8'b01000000, StOut  = 8'b10000000
  } state_e;
  state_e st_q;

  logic [LW-1:0] fill_q [JC];
  logic [PW-1:0] wptr_q [JC];
  logic signed [smapd_pkg::SumW-1:0] sum_q [JC];
  logic signed [18:0] zero_q [JC];
  logic signed [19:0] held_q [JC];

  smapd_pkg::item_t it_q;
  logic [LW-1:0] len;
  logic [PW-1:0] ptr;
  logic [AW-1:0] addr;
  logic we;
  logic [18:0] rdata;
  logic signed [smapd_pkg::SumW-1:0] nsum_d;
  logic [LW-1:0] nfill_d;
  logic div_start, div_done;
  logic [23:0] quo;
  logic signed [19:0] avg;
  logic signed [20:0] diff_q;
  logic signed [39:0] prod_q;
  logic signed [19:0] des_q;
  logic signed [37:0] pterm_q, dterm_q;
  logic signed [38:0] acc;
  logic [38:0] mag;
  logic signed [27:0] tq;
  logic signed [19:0] tsat;
  logic tsat_f;
  logic [39:0] pmag;
  logic signed [20:0] dres;
  logic [3:0] j;

  assign j = it_q.joint;

  // effective window length
  always_comb begin
    if (win_len_i == 7'd0) len = LW'(1);
    else if (32'(win_len_i) > WindowDepth) len = LW'(WindowDepth);
    else len = LW'(win_len_i);
  end
  assign ptr  = (32'(wptr_q[j]) >= 32'(len)) ? '0 : wptr_q[j];
  assign addr = AW'(32'(j) * WindowDepth + 32'(ptr));
  assign we   = (st_q == StSum);

  smapd_ram #(.Width(19), .Depth(JC * WindowDepth)) u_ram (
    .clk_i, .we_i(we), .addr_i(addr), .wdata_i(it_q.sample), .rdata_o(rdata)
  );

  assign div_start = (st_q == StSum);
  smapd_divider #(.NumW(24), .DenW(LW)) u_div (
    .clk_i, .rst_ni, .start_i(div_start),
    .num_i(nsum_d < 0 ? 24'(-nsum_d) : 24'(nsum_d)),
    .den_i(nfill_d), .done_o(div_done), .quo_o(quo)
  );
  // sign taken from the running sum stored when the division started
  assign avg = sum_q[j] < 0 ? -$signed(20'(quo)) : $signed(20'(quo));

  // rounding helpers
  always_comb begin
    pmag = prod_q < 0 ? 40'(-prod_q) : 40'(prod_q);
    pmag = (pmag + 40'd524288) >> 20;
    dres = prod_q < 0 ? -$signed(21'(pmag)) : $signed(21'(pmag));
    acc  = 39'(pterm_q) - 39'(dterm_q);
    mag  = acc < 0 ? 39'(-acc) : 39'(acc);
    mag  = (mag + 39'd2048) >> 12;
    tq   = acc < 0 ? -$signed(28'(mag)) : $signed(28'(mag));
    tsat_f = 1'b0;
    tsat = 20'(tq);
    if (tq > 28'(smapd_pkg::TorqueMax)) begin
      tsat = smapd_pkg::TorqueMax; tsat_f = 1'b1;
    end
    if (tq < 28'(smapd_pkg::TorqueMin)) begin
      tsat = smapd_pkg::TorqueMin; tsat_f = 1'b1;
    end
  end

  assign item_pop_o = (st_q == StIdle) && item_valid_i && !out_o.valid;

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
      out_o.valid <= 1'b0;
      for (int i = 0; i < JC; i++) begin
        fill_q[i] <= '0; wptr_q[i] <= '0; sum_q[i] <= '0;
        zero_q[i] <= '0; held_q[i] <= '0;
      end
    end else begin
      if (out_o.valid && out_o.ready) out_o.valid <= 1'b0;
      if (win_clear_i) begin
        for (int i = 0; i < JC; i++) begin
          fill_q[i] <= '0; wptr_q[i] <= '0; sum_q[i] <= '0;
        end
      end
      case (st_q)
        StIdle: if (item_pop_o) st_q <= StRead;
        StRead: begin
          if (!it_q.valid_joint) begin
            out_o.torque <= '0; out_o.desired_position <= '0;
            out_o.saturated <= 1'b0; out_o.valid <= 1'b1; st_q <= StIdle;
          end else if (it_q.capture) begin
            zero_q[j] <= it_q.sample;
            fill_q[j] <= '0; wptr_q[j] <= '0; sum_q[j] <= '0;
            out_o.torque <= held_q[j]; out_o.desired_position <= '0;
            out_o.saturated <= 1'b0; out_o.valid <= 1'b1; st_q <= StIdle;
          end else st_q <= StSum;
        end
        StSum: begin
          fill_q[j] <= nfill_d;
          sum_q[j]  <= nsum_d;
          wptr_q[j] <= (32'(ptr) + 1 >= 32'(len)) ? '0 : PW'(32'(ptr) + 1);
          st_q <= StDiv;
        end
        StDiv: if (div_done) begin
          diff_q <= 21'(avg) - 21'(zero_q[j]);
          st_q <= StMul;
        end
        StMul: begin
          prod_q <= 40'(diff_q) * $signed({22'd0, smapd_pkg::PiQ16});
          st_q <= StPd1;
        end
        StPd1: begin
          des_q <= 20'(dres);
          pterm_q <= 38'($signed({1'b0, gain_p_i})) * 38'(21'(dres) - 21'(it_q.position));
          dterm_q <= 38'($signed({1'b0, gain_d_i})) * 38'(it_q.velocity) * 38'sd16;
          st_q <= StPd2;
        end
        StPd2: begin
          if (it_q.enabled) begin
            held_q[j] <= tsat; out_o.torque <= tsat; out_o.saturated <= tsat_f;
          end else begin
            out_o.torque <= held_q[j]; out_o.saturated <= 1'b0;
          end
          out_o.desired_position <= des_q;
          out_o.valid <= 1'b1;
          st_q <= StIdle;
        end
        default: st_q <= StIdle;
      endcase
    end
  end

  // item capture and window arithmetic; ram read data valid in StSum
  always_comb begin
    if (32'(fill_q[j]) >= 32'(len)) begin
      nfill_d = len;
      nsum_d  = sum_q[j] - 25'($signed(rdata)) + 25'(it_q.sample);
    end else begin
      nfill_d = fill_q[j] + 1'b1;
      nsum_d  = sum_q[j] + 25'(it_q.sample);
    end
  end
  always_ff @(posedge clk_i) begin
    if (item_pop_o) it_q <= item_i;
  end
endmodule

@@ sim/smapd_tb_if.sv @@
`timescale 1ns / 1ps
// testbench package: input and result transaction types
// channel interfaces are taken from the rtl (smapd_if.sv); no other dependencies
package smapd_tb_pkg;
  // one input transaction as the testbench sees it
  typedef struct packed {
    logic               command;
    logic [3:0]         joint;
    logic [15:0]        knob_a;
    logic [15:0]        knob_b;
    logic signed [15:0] joint_position;
    logic signed [15:0] joint_velocity;
    logic               motor_on;
  } tick_t;

  // one result transaction
  typedef struct packed {
    logic signed [19:0] torque;
    logic signed [19:0] desired_position;
    logic               saturated;
  } drive_t;
endpackage

@@ sim/testbench.sv @@
`timescale 1ns / 1ps
// testbench for slider_moving_average_pd_joint: directed table then random ticks
// checked against an in-bench pd/moving-average predictor; depends on smapd_pkg,
// smapd_if and smapd_tb_pkg
module testbench;
  localparam int Depth = smapd_pkg::WindowDepth;
  localparam int Joints = smapd_pkg::JointCount;
  localparam int WatchLimit = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  smapd_in_if  in_ch();
  smapd_out_if out_ch();
  smapd_cfg_if cfg_ch();

  slider_moving_average_pd_joint dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_i(in_ch), .out_o(out_ch), .cfg_i(cfg_ch)
  );

  // clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // controller state mirror
  logic [15:0] kp, kd;
  logic [6:0]  win_len;
  logic signed [18:0] win_mem [Joints][Depth];
  int unsigned fill [Joints];
  int unsigned wptr [Joints];
  longint      wsum [Joints];
  longint      zero [Joints];
  longint      hold [Joints];

  smapd_tb_pkg::drive_t expected_q[$];
  int errors = 0;
  int idle_cycles = 0;
  bit hold_off = 1'b0;

  function automatic longint round_away(longint v, int sh);
    longint m;
    m = (v < 0) ? -v : v;
    m = (m + (longint'(1) << (sh - 1))) >>> sh;
    return (v < 0) ? -m : m;
  endfunction

  function automatic longint slider_map(int j, logic [15:0] a, logic [15:0] b);
    longint v;
    int leg, axis;
    leg = j / 3;
    axis = j % 3;
    if (axis == 0) v = longint'(a) - 32768;
    else if (axis == 1) v = longint'(b);
    else v = 131072 - 2 * longint'(b);
    if (leg >= 2 && axis != 0) v = -v;
    if (j == 3 || j == 9) v = -v;
    return v;
  endfunction

  function automatic void clear_joint(int j);
    fill[j] = 0;
    wptr[j] = 0;
    wsum[j] = 0;
  endfunction

  function automatic void reset_state();
    kp = 16'd4608;
    kd = 16'd92;
    win_len = 7'd50;
    for (int j = 0; j < Joints; j++) begin
      clear_joint(j);
      zero[j] = 0;
      hold[j] = 0;
    end
  endfunction

  // predicted result of one accepted tick
  function automatic smapd_tb_pkg::drive_t predict_torque(smapd_tb_pkg::tick_t t);
    smapd_tb_pkg::drive_t r;
    int j, len;
    longint smp, mag, avg, des, acc, trq, pos, vel;
    bit sat;
    r = '0;
    j = t.joint;
    if (j >= Joints) return r;
    smp = slider_map(j, t.knob_a, t.knob_b);
    if (t.command == smapd_pkg::CmdCapture) begin
      zero[j] = smp;
      clear_joint(j);
      r.torque = hold[j][19:0];
      return r;
    end
    len = (win_len == 0) ? 1 : (win_len > Depth) ? Depth : win_len;
    if (wptr[j] >= len) wptr[j] = 0;
    if (fill[j] >= len) begin
      wsum[j] -= win_mem[j][wptr[j]];
      fill[j] = len;
    end else begin
      fill[j]++;
    end
    win_mem[j][wptr[j]] = smp[18:0];
    wsum[j] += smp;
    wptr[j] = (wptr[j] + 1 >= len) ? 0 : wptr[j] + 1;
    mag = (wsum[j] < 0) ? -wsum[j] : wsum[j];
    mag = mag / fill[j];
    avg = (wsum[j] < 0) ? -mag : mag;
    des = round_away((avg - zero[j]) * 205887, 20);
    pos = longint'($signed(t.joint_position));
    vel = longint'($signed(t.joint_velocity));
    acc = longint'(kp) * (des - pos) - longint'(kd) * vel * 16;
    trq = round_away(acc, 12);
    sat = 1'b0;
    if (trq > 524287) begin trq = 524287; sat = 1'b1; end
    if (trq < -524288) begin trq = -524288; sat = 1'b1; end
    if (t.motor_on) hold[j] = trq;
    else sat = 1'b0;
    r.torque = hold[j][19:0];
    r.desired_position = des[19:0];
    r.saturated = sat;
    return r;
  endfunction

  // send one tick, sender side bursts handled by caller
  task automatic send_tick(smapd_tb_pkg::tick_t t);
    in_ch.valid <= 1'b1;
    in_ch.command <= t.command;
    in_ch.joint <= t.joint;
    in_ch.knob_a <= t.knob_a;
    in_ch.knob_b <= t.knob_b;
    in_ch.joint_position <= t.joint_position;
    in_ch.joint_velocity <= t.joint_velocity;
    in_ch.motor_on <= t.motor_on;
    do @(posedge clk_i); while (!in_ch.ready);
    expected_q.insert(expected_q.size(), predict_torque(t));
  endtask

  task automatic idle_in(int n);
    in_ch.valid <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    if (idx == smapd_pkg::RegGainP) kp = val;
    else if (idx == smapd_pkg::RegGainD) kd = val;
    else if (idx == smapd_pkg::RegWinLen) begin
      win_len = val[6:0];
      for (int j = 0; j < Joints; j++) clear_joint(j);
    end
  endtask

  function automatic smapd_tb_pkg::tick_t rand_tick(bit wild);
    smapd_tb_pkg::tick_t t;
    t.command = ($urandom_range(0, 19) != 0) ? smapd_pkg::CmdTick : smapd_pkg::CmdCapture;
    t.joint = wild ? 4'($urandom) : 4'($urandom_range(0, Joints - 1));
    t.knob_a = 16'($urandom);
    t.knob_b = 16'($urandom);
    case ($urandom_range(0, 3))
      0: t.joint_position = 16'($urandom);
      default: t.joint_position = 16'(int'($urandom_range(0, 8192)) - 4096);
    endcase
    case ($urandom_range(0, 3))
      0: t.joint_velocity = 16'($urandom);
      default: t.joint_velocity = 16'(int'($urandom_range(0, 512)) - 256);
    endcase
    t.motor_on = ($urandom_range(0, 5) != 0);
    return t;
  endfunction

  // directed rows: command, joint, a, b, pos, vel, en, check-literal, expected
  typedef struct {
    smapd_tb_pkg::tick_t  t;
    bit                   literal;
    smapd_tb_pkg::drive_t want;
  } row_t;

  row_t rows[$];

  function automatic row_t mk(logic c, logic [3:0] j, logic [15:0] a, logic [15:0] b,
      logic [15:0] p, logic [15:0] v, logic e, bit lit, smapd_tb_pkg::drive_t w);
    row_t r;
    r.t = {c, j, a, b, p, v, e};
    r.literal = lit;
    r.want = w;
    return r;
  endfunction

  // receiver: stalls at random, plus a long hold-off on request
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= !hold_off && ($urandom_range(0, 3) != 0 || $urandom_range(0, 1));
    end
  end

  // result checker
  always @(posedge clk_i) begin
    smapd_tb_pkg::drive_t exp_r;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (expected_q.size() == 0) begin
        $error("result transaction with nothing expected");
        errors++;
      end else begin
        exp_r = expected_q[0];
        expected_q.delete(0);
        if (out_ch.torque !== exp_r.torque) begin
          $error("torque expected %0d got %0d", exp_r.torque, out_ch.torque);
          errors++;
        end
        if (out_ch.desired_position !== exp_r.desired_position) begin
          $error("desired_position expected %0d got %0d", exp_r.desired_position,
                 out_ch.desired_position);
          errors++;
        end
        if (out_ch.saturated !== exp_r.saturated) begin
          $error("saturated expected %0d got %0d", exp_r.saturated, out_ch.saturated);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else if (rst_ni) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchLimit) begin
        $display("testbench NOT OK");
        $finish;
      end
    end
  end

  initial begin
    smapd_tb_pkg::drive_t zr;
    smapd_tb_pkg::drive_t sat_hi;
    int n;
    bit stall_done;
    in_ch.valid = 1'b0;
    in_ch.command = smapd_pkg::CmdTick;
    in_ch.joint = '0;
    in_ch.knob_a = '0;
    in_ch.knob_b = '0;
    in_ch.joint_position = '0;
    in_ch.joint_velocity = '0;
    in_ch.motor_on = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = smapd_pkg::RegGainP;
    cfg_ch.data = '0;
    stall_done = 1'b0;
    reset_state();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    zr = '0;
    sat_hi = '0;
    sat_hi.torque = 20'sd524287;
    sat_hi.desired_position = 20'sd0;
    sat_hi.saturated = 1'b1;
    // capture after reset gives zero torque, out-of-range joints give zeros
    rows.insert(rows.size(), mk(smapd_pkg::CmdCapture, 4'd0, 16'h8000, 16'h0000,
                16'h0000, 16'h0000, 1'b1, 1'b1, zr));
    rows.insert(rows.size(), mk(smapd_pkg::CmdTick, 4'd12, 16'hFFFF, 16'hFFFF,
                16'h7FFF, 16'h8000, 1'b1, 1'b1, zr));
    rows.insert(rows.size(), mk(smapd_pkg::CmdTick, 4'd15, 16'h0000, 16'h0000,
                16'h8000, 16'h7FFF, 1'b1, 1'b1, zr));
    // zero desired, most negative position and velocity at full p gain clips high
    rows.insert(rows.size(), mk(smapd_pkg::CmdTick, 4'd0, 16'h8000, 16'h0000,
                16'h8000, 16'h8000, 1'b1, 1'b1, sat_hi));
    for (int j = 0; j < Joints; j++) begin
      rows.insert(rows.size(), mk(smapd_pkg::CmdTick, 4'(j), 16'hFFFF, 16'hFFFF,
                  16'h7FFF, 16'h7FFF, 1'b1, 1'b0, zr));
      rows.insert(rows.size(), mk(smapd_pkg::CmdTick, 4'(j), 16'h0000, 16'h0000,
                  16'h8000, 16'h8000, 1'(j % 2), 1'b0, zr));
    end
    rows.insert(rows.size(), mk(smapd_pkg::CmdCapture, 4'd3, 16'h1234, 16'hFFFF,
                16'h0000, 16'h0000, 1'b0, 1'b0, zr));
    rows.insert(rows.size(), mk(smapd_pkg::CmdTick, 4'd3, 16'h1234, 16'h0000,
                16'h0100, 16'h0010, 1'b0, 1'b0, zr));

    write_reg(smapd_pkg::RegGainP, 16'hFFFF);
    foreach (rows[i]) begin
      send_tick(rows[i].t);
      if (rows[i].literal && expected_q[$] != rows[i].want) begin
        $error("directed row %0d expectation differs from predictor", i);
        errors++;
      end
    end
    drain();

    // random phases over several register settings, extremes included
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin write_reg(smapd_pkg::RegGainP, 16'd0);
                 write_reg(smapd_pkg::RegGainD, 16'd0);
                 write_reg(smapd_pkg::RegWinLen, 16'd1); end
        1: begin write_reg(smapd_pkg::RegGainP, 16'hFFFF);
                 write_reg(smapd_pkg::RegGainD, 16'hFFFF);
                 write_reg(smapd_pkg::RegWinLen, 16'd64); end
        2: write_reg(smapd_pkg::RegWinLen, 16'd0);
        3: write_reg(smapd_pkg::RegWinLen, 16'h007F);
        4: begin write_reg(smapd_pkg::RegGainP, 16'd4608);
                 write_reg(smapd_pkg::RegGainD, 16'd92);
                 write_reg(smapd_pkg::RegWinLen, 16'd3); end
        5: write_reg(smapd_pkg::RegWinLen, 16'hFF8A);
        default: begin write_reg(smapd_pkg::RegGainP, 16'($urandom));
                 write_reg(smapd_pkg::RegGainD, 16'($urandom));
                 write_reg(smapd_pkg::RegWinLen, 16'($urandom_range(1, 70))); end
      endcase
      n = 0;
      while (n < 185) begin
        // long receiver hold-off while the sender keeps offering
        if (ph == 2 && !stall_done && n >= 20) begin
          stall_done = 1'b1;
          fork
            begin hold_off = 1'b1; repeat (400) @(posedge clk_i); hold_off = 1'b0; end
          join_none
        end
        repeat ($urandom_range(1, 12)) begin
          send_tick(rand_tick($urandom_range(0, 15) == 0));
          n++;
        end
        if ($urandom_range(0, 2) == 0) idle_in($urandom_range(1, 30));
      end
      drain();
    end

    if (errors == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end
endmodule
